/* sv/csu_pkg.sv */
// Shared types, codes and helpers of the cubic spline upsampler.
// Used by the interfaces, controller, datapath and divider; no dependencies.
package csu_pkg;

  localparam int unsigned PIX_W    = 8;
  localparam int unsigned Q_W      = 6;
  localparam int unsigned J_W      = 6;
  localparam int unsigned DIV_W    = 64;
  localparam int unsigned DIV_CNT_W = 7;
  localparam logic [Q_W-1:0] Q_MAX = 6'd32;
  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
  localparam int unsigned EMIT_STEPS = 10;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EMIT = 1'b1;

  typedef enum logic [3:0] {
    MOP_NONE = 4'd0,
    MOP_Q2   = 4'd1,
    MOP_Q3   = 4'd2,
    MOP_Q2J  = 4'd3,
    MOP_JJ   = 4'd4,
    MOP_JJJ  = 4'd5,
    MOP_QJJ  = 4'd6,
    MOP_T1   = 4'd7,
    MOP_T2   = 4'd8,
    MOP_T3   = 4'd9,
    MOP_T4   = 4'd10,
    MOP_T5   = 4'd11,
    MOP_CORR = 4'd12
  } mop_e;

  typedef enum logic [1:0] {
    CW_ZERO = 2'd0,
    CW_DIV  = 2'd1,
    CW_BACK = 2'd2
  } cw_sel_e;

  typedef enum logic [1:0] {
    DSEL_SWEEP = 2'd0,
    DSEL_RHS   = 2'd1,
    DSEL_EMIT  = 2'd2
  } dsel_e;

  // per output frame: coefficient products, then the five numerator terms
  localparam mop_e EMIT_SEQ [EMIT_STEPS] = '{
    MOP_JJ, MOP_Q2J, MOP_JJJ, MOP_QJJ, MOP_T1,
    MOP_T2, MOP_T3, MOP_T4, MOP_T5, MOP_NONE
  };

  typedef struct packed {
    logic    y_we;
    logic    s_we;
    logic    c_we;
    logic    s_wzero;
    cw_sel_e c_wsel;
    logic    cap_y0;
    logic    cap_y1;
    logic    cap_y2;
    logic    cap_s;
    logic    cap_ca;
    logic    cap_cb;
    mop_e    mop;
    logic    div_start;
    dsel_e   dsel;
  } ctrl_t;

  typedef struct packed {
    logic             div_done;
    logic [PIX_W-1:0] pixel;
    logic [PIX_W-1:0] y1;
  } stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

/* sv/csu_in_if.sv */
// Input channel of the upsampler: load or emit request items.
// Depends on csu_pkg for field widths.
interface csu_in_if;
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic [csu_pkg::PIX_W-1:0]  sample;
  logic                       last_sample;
  modport source (output valid, cmd, sample, last_sample, input ready);
  modport sink   (input valid, cmd, sample, last_sample, output ready);
endinterface

/* sv/csu_out_if.sv */
// Output channel of the upsampler: interpolated pixel items.
// Depends on csu_pkg for field widths.
interface csu_out_if;
  logic                       valid;
  logic                       ready;
  logic [csu_pkg::PIX_W-1:0]  pixel;
  logic                       segment_end;
  logic                       sequence_end;
  logic                       error;
  modport source (output valid, pixel, segment_end, sequence_end, error, input ready);
  modport sink   (input valid, pixel, segment_end, sequence_end, error, output ready);
endinterface

/* sv/csu_cfg_if.sv */
// Configuration write channel carrying the q_factor register.
// Depends on csu_pkg for the field width.
interface csu_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [csu_pkg::Q_W-1:0]  q_factor;
  modport source (output valid, q_factor, input ready);
  modport sink   (input valid, q_factor, output ready);
endinterface

/* sv/csu_divider.sv */
// Bit-serial signed divider, quotient rounded half away from zero.
// One quotient bit per cycle; depends on csu_pkg.
module csu_divider (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [csu_pkg::DIV_W-1:0]    num_i,
  input  logic        [csu_pkg::DIV_W-1:0]    den_i,
  output logic                                done_o,
  output logic signed [csu_pkg::DIV_W-1:0]    quo_o
);
  localparam int unsigned W = csu_pkg::DIV_W;

  logic [W-1:0]                   rem_q, qt_q, den_q;
  logic                           neg_q, busy_q, done_q;
  logic [csu_pkg::DIV_CNT_W-1:0]  cnt_q;
  logic [W-1:0]                   mag;
  logic [W:0]                     rem_sh, rem_sub;
  logic                           ge;

  assign mag     = (num_i < 0 ? W'(-num_i) : W'(num_i)) + (den_i >> 1);
  assign rem_sh  = {rem_q, qt_q[W-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign ge      = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= csu_pkg::DIV_CNT_W'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == csu_pkg::DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      qt_q  <= mag;
      rem_q <= '0;
      den_q <= den_i;
      neg_q <= num_i < 0;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
      qt_q  <= {qt_q[W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed(qt_q) : $signed(qt_q);

endmodule

/* sv/csu_datapath.sv */
// Datapath: sample, sweep and second-order stores, shared multiplier,
// accumulator and divider. Depends on csu_pkg and csu_divider.
module csu_datapath #(
  parameter int unsigned MAX_SAMPLES = 64,
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned AW          = $clog2(MAX_SAMPLES)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  csu_pkg::ctrl_t                ctl_i,
  input  logic [AW-1:0]                 y_ra_i,
  input  logic [AW-1:0]                 s_ra_i,
  input  logic [AW-1:0]                 c_ra_i,
  input  logic [AW-1:0]                 y_wa_i,
  input  logic [AW-1:0]                 s_wa_i,
  input  logic [AW-1:0]                 c_wa_i,
  input  logic [csu_pkg::PIX_W-1:0]     sample_i,
  input  logic [csu_pkg::Q_W-1:0]       qe_i,
  input  logic [csu_pkg::J_W-1:0]       j_i,
  output csu_pkg::stat_t                stat_o
);
  localparam logic signed [63:0] ONE  = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] HALF = ONE >>> 1;

  logic [7:0]         y_mem [MAX_SAMPLES];
  logic signed [31:0] s_mem [MAX_SAMPLES];
  logic signed [31:0] c_mem [MAX_SAMPLES];
  logic [7:0]         y_rd_q;
  logic signed [31:0] s_rd_q, c_rd_q;

  logic [7:0]         y0_q, y1_q, y2_q;
  logic signed [31:0] sw_q, ca_q, cb_q;
  logic [10:0]        q2_q;
  logic [15:0]        q3_q;
  logic [14:0]        q2j_q, jjj_q, qjj_q;
  logic [9:0]         jj_q;
  logic signed [63:0] acc_q, prod_q;
  csu_pkg::mop_e      pend_q;

  logic signed [35:0] mul_a, mul_b;
  logic signed [71:0] prod_full;
  logic [17:0]        q3x3;
  logic [16:0]        q2jx3, qjjx3;
  logic signed [8:0]  dy;
  logic signed [34:0] c2;
  logic signed [32:0] cd;
  logic signed [9:0]  diff;
  logic signed [11:0] diff3;
  logic signed [63:0] rhs, corr, back;
  logic signed [63:0] div_num, div_quo;
  logic [63:0]        div_den;
  logic               div_done;
  logic signed [31:0] s_wd, c_wd;

  // stores
  always_ff @(posedge clk_i) begin
    if (ctl_i.y_we) y_mem[y_wa_i] <= sample_i;
    y_rd_q <= y_mem[y_ra_i];
  end
  always_ff @(posedge clk_i) begin
    if (ctl_i.s_we) s_mem[s_wa_i] <= s_wd;
    s_rd_q <= s_mem[s_ra_i];
  end
  always_ff @(posedge clk_i) begin
    if (ctl_i.c_we) c_mem[c_wa_i] <= c_wd;
    c_rd_q <= c_mem[c_ra_i];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.cap_y0) y0_q <= y_rd_q;
    if (ctl_i.cap_y1) y1_q <= y_rd_q;
    if (ctl_i.cap_y2) y2_q <= y_rd_q;
    if (ctl_i.cap_s)  sw_q <= s_rd_q;
    if (ctl_i.cap_ca) ca_q <= c_rd_q;
    if (ctl_i.cap_cb) cb_q <= c_rd_q;
  end

  assign q3x3  = {1'b0, q3_q, 1'b0} + 18'(q3_q);
  assign q2jx3 = {1'b0, q2j_q, 1'b0} + 17'(q2j_q);
  assign qjjx3 = {1'b0, qjj_q, 1'b0} + 17'(qjj_q);
  assign dy    = $signed({1'b0, y1_q}) - $signed({1'b0, y0_q});
  assign c2    = (35'(ca_q) <<< 1) + 35'(cb_q);
  assign cd    = 33'(cb_q) - 33'(ca_q);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctl_i.mop)
      csu_pkg::MOP_Q2:   begin mul_a = 36'(qe_i);  mul_b = 36'(qe_i); end
      csu_pkg::MOP_Q3:   begin mul_a = 36'(q2_q);  mul_b = 36'(qe_i); end
      csu_pkg::MOP_Q2J:  begin mul_a = 36'(q2_q);  mul_b = 36'(j_i);  end
      csu_pkg::MOP_JJ:   begin mul_a = 36'(j_i);   mul_b = 36'(j_i);  end
      csu_pkg::MOP_JJJ:  begin mul_a = 36'(jj_q);  mul_b = 36'(j_i);  end
      csu_pkg::MOP_QJJ:  begin mul_a = 36'(qe_i);  mul_b = 36'(jj_q); end
      csu_pkg::MOP_T1:   begin mul_a = 36'(q3x3);  mul_b = 36'(y0_q); end
      csu_pkg::MOP_T2:   begin mul_a = 36'(q2jx3); mul_b = 36'(dy);   end
      csu_pkg::MOP_T3:   begin mul_a = 36'(q2j_q); mul_b = 36'(c2);   end
      csu_pkg::MOP_T4:   begin mul_a = 36'(qjjx3); mul_b = 36'(ca_q); end
      csu_pkg::MOP_T5:   begin mul_a = 36'(jjj_q); mul_b = 36'(cd);   end
      csu_pkg::MOP_CORR: begin mul_a = 36'(sw_q);  mul_b = 36'(ca_q); end
      default: ;
    endcase
  end

  assign prod_full = mul_a * mul_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= csu_pkg::MOP_NONE;
    end else begin
      pend_q <= ctl_i.mop;
    end
  end

  // product registered, folded into its destination in the following cycle
  always_ff @(posedge clk_i) begin
    prod_q <= prod_full[63:0];
    case (pend_q)
      csu_pkg::MOP_Q2:   q2_q  <= prod_q[10:0];
      csu_pkg::MOP_Q3:   q3_q  <= prod_q[15:0];
      csu_pkg::MOP_Q2J:  q2j_q <= prod_q[14:0];
      csu_pkg::MOP_JJ:   jj_q  <= prod_q[9:0];
      csu_pkg::MOP_JJJ:  jjj_q <= prod_q[14:0];
      csu_pkg::MOP_QJJ:  qjj_q <= prod_q[14:0];
      csu_pkg::MOP_T1:   acc_q <= prod_q <<< FRAC_BITS;
      csu_pkg::MOP_T2:   acc_q <= acc_q + (prod_q <<< FRAC_BITS);
      csu_pkg::MOP_T3:   acc_q <= acc_q - prod_q;
      csu_pkg::MOP_T4:   acc_q <= acc_q + prod_q;
      csu_pkg::MOP_T5:   acc_q <= acc_q + prod_q;
      csu_pkg::MOP_CORR: acc_q <= prod_q;
      default: ;
    endcase
  end

  assign diff  = $signed({2'b0, y0_q}) - $signed({1'b0, y1_q, 1'b0}) + $signed({2'b0, y2_q});
  assign diff3 = (12'(diff) <<< 1) + 12'(diff);
  assign rhs   = (64'(diff3) <<< FRAC_BITS) - 64'(ca_q);

  always_comb begin
    div_num = ONE <<< FRAC_BITS;
    div_den = 64'((ONE <<< 2) - 64'(sw_q));
    case (ctl_i.dsel)
      csu_pkg::DSEL_SWEEP: ;
      csu_pkg::DSEL_RHS:   div_num = rhs <<< FRAC_BITS;
      csu_pkg::DSEL_EMIT: begin
        div_num = acc_q;
        div_den = 64'(q3x3) << FRAC_BITS;
      end
      default: ;
    endcase
  end

  csu_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctl_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign corr = (acc_q >= 0) ? ((acc_q + HALF) >>> FRAC_BITS)
                             : -((-acc_q + HALF) >>> FRAC_BITS);
  assign back = 64'(cb_q) - corr;

  assign s_wd = ctl_i.s_wzero ? 32'sd0 : csu_pkg::sat32(div_quo);

  always_comb begin
    case (ctl_i.c_wsel)
      csu_pkg::CW_DIV:  c_wd = csu_pkg::sat32(div_quo);
      csu_pkg::CW_BACK: c_wd = csu_pkg::sat32(back);
      default:          c_wd = 32'sd0;
    endcase
  end

  always_comb begin
    stat_o.div_done = div_done;
    stat_o.y1       = y1_q;
    if (div_quo < 0) begin
      stat_o.pixel = '0;
    end else if (div_quo > 64'sd255) begin
      stat_o.pixel = csu_pkg::PIX_MAX;
    end else begin
      stat_o.pixel = div_quo[7:0];
    end
  end

endmodule

/* sv/csu_ctrl.sv */
// Controller: request handling, solve and emit sequencing, counters,
// q_factor register and output item register. Depends on csu_pkg.
module csu_ctrl #(
  parameter int unsigned MAX_SAMPLES = 64,
  parameter int unsigned AW          = $clog2(MAX_SAMPLES),
  parameter int unsigned CW          = $clog2(MAX_SAMPLES + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       in_cmd_i,
  input  logic                       in_last_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [csu_pkg::Q_W-1:0]    cfg_q_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [csu_pkg::PIX_W-1:0]  out_pixel_o,
  output logic                       out_seg_end_o,
  output logic                       out_seq_end_o,
  output logic                       out_error_o,
  input  csu_pkg::stat_t             stat_i,
  output csu_pkg::ctrl_t             ctl_o,
  output logic [AW-1:0]              y_ra_o,
  output logic [AW-1:0]              s_ra_o,
  output logic [AW-1:0]              c_ra_o,
  output logic [AW-1:0]              y_wa_o,
  output logic [AW-1:0]              s_wa_o,
  output logic [AW-1:0]              c_wa_o,
  output logic [csu_pkg::Q_W-1:0]    qe_o,
  output logic [csu_pkg::J_W-1:0]    j_o
);
  typedef enum logic [26:0] {
    ST_IDLE   = 27'd1 << 0,
    ST_F_INIT = 27'd1 << 1,
    ST_F_RA   = 27'd1 << 2,
    ST_F_RB   = 27'd1 << 3,
    ST_F_RC   = 27'd1 << 4,
    ST_F_RD   = 27'd1 << 5,
    ST_F_DS   = 27'd1 << 6,
    ST_F_DW   = 27'd1 << 7,
    ST_F_RS   = 27'd1 << 8,
    ST_F_RW   = 27'd1 << 9,
    ST_F_END  = 27'd1 << 10,
    ST_B_RA   = 27'd1 << 11,
    ST_B_RB   = 27'd1 << 12,
    ST_B_RC   = 27'd1 << 13,
    ST_B_WT   = 27'd1 << 14,
    ST_B_WR   = 27'd1 << 15,
    ST_S_DONE = 27'd1 << 16,
    ST_E_RA   = 27'd1 << 17,
    ST_E_RB   = 27'd1 << 18,
    ST_E_RC   = 27'd1 << 19,
    ST_E_WQ   = 27'd1 << 20,
    ST_E_OP   = 27'd1 << 21,
    ST_E_DS   = 27'd1 << 22,
    ST_E_DW   = 27'd1 << 23,
    ST_E_PUSH = 27'd1 << 24,
    ST_E_FIN  = 27'd1 << 25,
    ST_ERR    = 27'd1 << 26
  } state_e;

  state_e                     state_q, state_d;
  logic [CW-1:0]              cnt_q, cnt_d;
  logic [AW-1:0]              seg_q, seg_d;
  logic                       solved_q, solved_d;
  logic [AW-1:0]              i_q, i_d;
  logic [csu_pkg::J_W-1:0]    j_q, j_d;
  logic [csu_pkg::Q_W-1:0]    qe_q, qe_d;
  logic                       final_q, final_d;
  logic [3:0]                 step_q, step_d;
  logic [csu_pkg::Q_W-1:0]    qreg_q;

  logic                       ov_q, ov_d;
  logic [csu_pkg::PIX_W-1:0]  opix_q, opix_d;
  logic                       oseg_q, oseg_d, oseq_q, oseq_d, oerr_q, oerr_d;

  logic [CW-1:0]              cnt_eff, cnt_m1, cnt_m2;
  logic [CW:0]                seg_p1;
  logic [AW-1:0]              emit_i;
  logic                       out_free;
  logic [csu_pkg::Q_W-1:0]    q_clamp;

  assign cnt_eff  = solved_q ? '0 : cnt_q;
  assign cnt_m1   = cnt_q - CW'(1);
  assign cnt_m2   = cnt_q - CW'(2);
  assign seg_p1   = (CW+1)'(seg_q) + 1'b1;
  assign emit_i   = (seg_p1 >= (CW+1)'(cnt_q)) ? cnt_m2[AW-1:0] : seg_q;
  assign out_free = !ov_q || out_ready_i;
  assign q_clamp  = (qreg_q == '0) ? csu_pkg::Q_W'(1) :
                    (qreg_q > csu_pkg::Q_MAX) ? csu_pkg::Q_MAX : qreg_q;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    seg_d    = seg_q;
    solved_d = solved_q;
    i_d      = i_q;
    j_d      = j_q;
    qe_d     = qe_q;
    final_d  = final_q;
    step_d   = step_q;
    ov_d     = ov_q && !out_ready_i;
    opix_d   = opix_q;
    oseg_d   = oseg_q;
    oseq_d   = oseq_q;
    oerr_d   = oerr_q;
    ctl_o    = '0;
    ctl_o.mop    = csu_pkg::MOP_NONE;
    ctl_o.c_wsel = csu_pkg::CW_ZERO;
    ctl_o.dsel   = csu_pkg::DSEL_SWEEP;
    y_ra_o   = i_q;
    s_ra_o   = i_q;
    c_ra_o   = i_q;
    y_wa_o   = cnt_eff[AW-1:0];
    s_wa_o   = i_q;
    c_wa_o   = i_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_cmd_i == csu_pkg::CMD_LOAD) begin
            if (solved_q) begin
              solved_d = 1'b0;
              seg_d    = '0;
            end
            cnt_d = cnt_eff;
            if (cnt_eff < CW'(MAX_SAMPLES)) begin
              ctl_o.y_we = 1'b1;
              cnt_d      = cnt_eff + 1'b1;
            end
            if (in_last_i) state_d = ST_F_INIT;
          end else if (!solved_q || cnt_q < CW'(2)) begin
            if (solved_q) begin
              solved_d = 1'b0;
              cnt_d    = '0;
              seg_d    = '0;
            end
            state_d = ST_ERR;
          end else begin
            i_d     = emit_i;
            final_d = (CW'(emit_i) + CW'(2)) == cnt_q;
            qe_d    = q_clamp;
            j_d     = '0;
            state_d = ST_E_RA;
          end
        end
      end
      ST_F_INIT: begin
        if (cnt_q < CW'(2)) begin
          state_d = ST_S_DONE;
        end else begin
          ctl_o.s_we    = 1'b1;
          ctl_o.s_wzero = 1'b1;
          ctl_o.c_we    = 1'b1;
          s_wa_o        = '0;
          c_wa_o        = '0;
          i_d           = AW'(1);
          state_d       = (cnt_q == CW'(2)) ? ST_F_END : ST_F_RA;
        end
      end
      ST_F_RA: begin
        y_ra_o  = i_q - 1'b1;
        s_ra_o  = i_q - 1'b1;
        c_ra_o  = i_q - 1'b1;
        state_d = ST_F_RB;
      end
      ST_F_RB: begin
        ctl_o.cap_y0 = 1'b1;
        ctl_o.cap_s  = 1'b1;
        ctl_o.cap_ca = 1'b1;
        state_d      = ST_F_RC;
      end
      ST_F_RC: begin
        ctl_o.cap_y1 = 1'b1;
        y_ra_o       = i_q + 1'b1;
        state_d      = ST_F_RD;
      end
      ST_F_RD: begin
        ctl_o.cap_y2 = 1'b1;
        state_d      = ST_F_DS;
      end
      ST_F_DS: begin
        ctl_o.div_start = 1'b1;
        state_d         = ST_F_DW;
      end
      ST_F_DW: begin
        if (stat_i.div_done) begin
          ctl_o.s_we = 1'b1;
          state_d    = ST_F_RS;
        end
      end
      ST_F_RS: begin
        ctl_o.div_start = 1'b1;
        ctl_o.dsel      = csu_pkg::DSEL_RHS;
        state_d         = ST_F_RW;
      end
      ST_F_RW: begin
        ctl_o.dsel = csu_pkg::DSEL_RHS;
        if (stat_i.div_done) begin
          ctl_o.c_we   = 1'b1;
          ctl_o.c_wsel = csu_pkg::CW_DIV;
          if ((CW'(i_q) + CW'(2)) == cnt_q) begin
            state_d = ST_F_END;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = ST_F_RA;
          end
        end
      end
      ST_F_END: begin
        ctl_o.s_we    = 1'b1;
        ctl_o.s_wzero = 1'b1;
        ctl_o.c_we    = 1'b1;
        s_wa_o        = cnt_m1[AW-1:0];
        c_wa_o        = cnt_m1[AW-1:0];
        i_d           = cnt_m2[AW-1:0];
        state_d       = (cnt_q >= CW'(3)) ? ST_B_RA : ST_S_DONE;
      end
      ST_B_RA: begin
        c_ra_o  = i_q + 1'b1;
        state_d = ST_B_RB;
      end
      ST_B_RB: begin
        ctl_o.cap_s  = 1'b1;
        ctl_o.cap_ca = 1'b1;
        state_d      = ST_B_RC;
      end
      ST_B_RC: begin
        ctl_o.cap_cb = 1'b1;
        ctl_o.mop    = csu_pkg::MOP_CORR;
        state_d      = ST_B_WT;
      end
      ST_B_WT: state_d = ST_B_WR;
      ST_B_WR: begin
        ctl_o.c_we   = 1'b1;
        ctl_o.c_wsel = csu_pkg::CW_BACK;
        if (i_q == AW'(1)) begin
          state_d = ST_S_DONE;
        end else begin
          i_d     = i_q - 1'b1;
          state_d = ST_B_RA;
        end
      end
      ST_S_DONE: begin
        solved_d = 1'b1;
        seg_d    = '0;
        state_d  = ST_IDLE;
      end
      ST_E_RA: begin
        ctl_o.mop = csu_pkg::MOP_Q2;
        state_d   = ST_E_RB;
      end
      ST_E_RB: begin
        ctl_o.cap_y0 = 1'b1;
        ctl_o.cap_ca = 1'b1;
        y_ra_o       = i_q + 1'b1;
        c_ra_o       = i_q + 1'b1;
        state_d      = ST_E_RC;
      end
      ST_E_RC: begin
        ctl_o.cap_y1 = 1'b1;
        ctl_o.cap_cb = 1'b1;
        ctl_o.mop    = csu_pkg::MOP_Q3;
        state_d      = ST_E_WQ;
      end
      ST_E_WQ: begin
        step_d  = '0;
        state_d = ST_E_OP;
      end
      ST_E_OP: begin
        ctl_o.mop = csu_pkg::EMIT_SEQ[step_q];
        if (step_q == 4'(csu_pkg::EMIT_STEPS - 1)) begin
          state_d = ST_E_DS;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_E_DS: begin
        ctl_o.div_start = 1'b1;
        ctl_o.dsel      = csu_pkg::DSEL_EMIT;
        state_d         = ST_E_DW;
      end
      ST_E_DW: begin
        if (stat_i.div_done) state_d = ST_E_PUSH;
      end
      ST_E_PUSH: begin
        if (out_free) begin
          ov_d   = 1'b1;
          opix_d = stat_i.pixel;
          oseq_d = 1'b0;
          oerr_d = 1'b0;
          oseg_d = !final_q && (j_q == qe_q - 1'b1);
          if (j_q == qe_q - 1'b1) begin
            if (final_q) begin
              state_d = ST_E_FIN;
            end else begin
              seg_d   = i_q + 1'b1;
              state_d = ST_IDLE;
            end
          end else begin
            j_d     = j_q + 1'b1;
            step_d  = '0;
            state_d = ST_E_OP;
          end
        end
      end
      ST_E_FIN: begin
        if (out_free) begin
          ov_d     = 1'b1;
          opix_d   = stat_i.y1;
          oseg_d   = 1'b1;
          oseq_d   = 1'b1;
          oerr_d   = 1'b0;
          solved_d = 1'b0;
          cnt_d    = '0;
          seg_d    = '0;
          state_d  = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (out_free) begin
          ov_d    = 1'b1;
          opix_d  = '0;
          oseg_d  = 1'b1;
          oseq_d  = 1'b0;
          oerr_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      seg_q    <= '0;
      solved_q <= 1'b0;
      i_q      <= '0;
      j_q      <= '0;
      qe_q     <= csu_pkg::Q_W'(1);
      final_q  <= 1'b0;
      step_q   <= '0;
      ov_q     <= 1'b0;
      qreg_q   <= csu_pkg::Q_W'(2);
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      seg_q    <= seg_d;
      solved_q <= solved_d;
      i_q      <= i_d;
      j_q      <= j_d;
      qe_q     <= qe_d;
      final_q  <= final_d;
      step_q   <= step_d;
      ov_q     <= ov_d;
      if (cfg_valid_i) qreg_q <= cfg_q_i;
    end
  end

  always_ff @(posedge clk_i) begin
    opix_q <= opix_d;
    oseg_q <= oseg_d;
    oseq_q <= oseq_d;
    oerr_q <= oerr_d;
  end

  assign in_ready_o    = state_q == ST_IDLE;
  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = ov_q;
  assign out_pixel_o   = opix_q;
  assign out_seg_end_o = oseg_q;
  assign out_seq_end_o = oseq_q;
  assign out_error_o   = oerr_q;
  assign qe_o          = qe_q;
  assign j_o           = j_q;

endmodule

/* sv/cubic_spline_temporal_upsampler_core.sv */
// Top level. Solve of n samples: a forward pass and a back pass over the inner
// knots, two divider quotients per knot in the forward pass. Emit: setup states
// E_RA to E_WQ, then per output value 10 multiply steps, a divide and one
// push, plus output stalls; the final segment adds one item. One item is
// handled at a time.
// Reset is asynchronous, active low: counters, solved flag and q_factor (2)
// are set; the three stores stay undefined until written.
module cubic_spline_temporal_upsampler_core #(
  parameter int unsigned MAX_SAMPLES = 64,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  csu_in_if.sink       in_i,
  csu_out_if.source    out_o,
  csu_cfg_if.sink      cfg_i
);
  localparam int unsigned AW = $clog2(MAX_SAMPLES);

  csu_pkg::ctrl_t              ctl;
  csu_pkg::stat_t              stat;
  logic [AW-1:0]               y_ra, s_ra, c_ra, y_wa, s_wa, c_wa;
  logic [csu_pkg::Q_W-1:0]     qe;
  logic [csu_pkg::J_W-1:0]     j;

  csu_ctrl #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_ready_o    (in_i.ready),
    .in_cmd_i      (in_i.cmd),
    .in_last_i     (in_i.last_sample),
    .cfg_valid_i   (cfg_i.valid),
    .cfg_ready_o   (cfg_i.ready),
    .cfg_q_i       (cfg_i.q_factor),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_pixel_o   (out_o.pixel),
    .out_seg_end_o (out_o.segment_end),
    .out_seq_end_o (out_o.sequence_end),
    .out_error_o   (out_o.error),
    .stat_i        (stat),
    .ctl_o         (ctl),
    .y_ra_o        (y_ra),
    .s_ra_o        (s_ra),
    .c_ra_o        (c_ra),
    .y_wa_o        (y_wa),
    .s_wa_o        (s_wa),
    .c_wa_o        (c_wa),
    .qe_o          (qe),
    .j_o           (j)
  );

  csu_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .y_ra_i   (y_ra),
    .s_ra_i   (s_ra),
    .c_ra_i   (c_ra),
    .y_wa_i   (y_wa),
    .s_wa_i   (s_wa),
    .c_wa_i   (c_wa),
    .sample_i (in_i.sample),
    .qe_i     (qe),
    .j_i      (j),
    .stat_o   (stat)
  );

endmodule

/* tb/tb_cubic_spline_temporal_upsampler_core.sv */
// Self-checking bench of the cubic spline temporal upsampler core: output items are predicted
// in fixed point from the load and emit items by a scoreboard class and compared field by field.
// Depends on csu_pkg, the csu_*_if interfaces and the core.
`timescale 1ns / 100ps

module tb_cubic_spline_temporal_upsampler_core;

  localparam int unsigned STORE_DEPTH = 64;
  localparam int unsigned FRAC = 16;
  localparam longint ONE = longint'(1) << FRAC;
  localparam int unsigned SETTLE_CYCLES = 10000;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic [csu_pkg::PIX_W-1:0] pixel;
    logic                      segment_end;
    logic                      sequence_end;
    logic                      error;
  } frame_t;

  class upsample_scoreboard;
    int          samples [STORE_DEPTH];
    int          curv [STORE_DEPTH];
    int          ratio [STORE_DEPTH];
    int unsigned count;
    int unsigned seg;
    bit          solved;
    logic [csu_pkg::Q_W-1:0] q_reg;
    frame_t      frames_due[$];
    int          mismatches;

    function new();
      count = 0;
      seg = 0;
      solved = 0;
      q_reg = 6'd2;
      mismatches = 0;
    endfunction

    function longint round_div(longint n, longint d);
      if (n >= 0) return (n + d / 2) / d;
      return -((-n + d / 2) / d);
    endfunction

    function int clip32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
    endfunction

    function void fit_spline();
      longint den, diff, rhs, corr;
      int i;
      if (count < 2) return;
      ratio[0] = 0;
      curv[0] = 0;
      for (i = 1; i < int'(count) - 1; i++) begin
        den = 4 * ONE - longint'(ratio[i-1]);
        diff = longint'(samples[i-1]) - 2 * longint'(samples[i]) + longint'(samples[i+1]);
        rhs = 3 * diff * ONE - longint'(curv[i-1]);
        ratio[i] = clip32(round_div(ONE * ONE, den));
        curv[i] = clip32(round_div(rhs * ONE, den));
      end
      ratio[count-1] = 0;
      curv[count-1] = 0;
      for (i = int'(count) - 2; i >= 1; i--) begin
        corr = round_div(longint'(ratio[i]) * longint'(curv[i+1]), ONE);
        curv[i] = clip32(longint'(curv[i]) - corr);
      end
    endfunction

    function void push(int pix, bit se, bit qe, bit er);
      frame_t f;
      f.pixel = pix[csu_pkg::PIX_W-1:0];
      f.segment_end = se;
      f.sequence_end = qe;
      f.error = er;
      frames_due.push_back(f);
    endfunction

    function void set_q(logic [csu_pkg::Q_W-1:0] v);
      q_reg = v;
    endfunction

    function void note_input(logic cmd, logic [csu_pkg::PIX_W-1:0] smp, logic last);
      longint q, y0, y1, c0, c1, q2, q3, den, j, num, v;
      int unsigned i;
      bit final_seg;
      if (cmd == csu_pkg::CMD_LOAD) begin
        if (solved) begin
          solved = 0;
          count = 0;
          seg = 0;
        end
        if (count < STORE_DEPTH) begin
          samples[count] = smp;
          count++;
        end
        if (last) begin
          fit_spline();
          solved = 1;
          seg = 0;
        end
        return;
      end
      if (!solved || count < 2) begin
        if (solved) begin
          solved = 0;
          count = 0;
          seg = 0;
        end
        push(0, 1'b1, 1'b0, 1'b1);
        return;
      end
      q = q_reg;
      if (q < 1) q = 1;
      if (q > 32) q = 32;
      i = seg;
      if (i + 1 >= count) i = count - 2;
      final_seg = (i + 2 == count);
      y0 = samples[i];
      y1 = samples[i+1];
      c0 = curv[i];
      c1 = curv[i+1];
      q2 = q * q;
      q3 = q2 * q;
      den = 3 * q3 * ONE;
      for (j = 0; j < q; j++) begin
        num = 3 * q3 * y0 * ONE + 3 * q2 * j * (y1 - y0) * ONE - q2 * j * (2 * c0 + c1)
            + 3 * q * j * j * c0 + j * j * j * (c1 - c0);
        v = round_div(num, den);
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        push(int'(v), (!final_seg && j == q - 1), 1'b0, 1'b0);
      end
      if (final_seg) begin
        push(int'(y1), 1'b1, 1'b1, 1'b0);
        solved = 0;
        count = 0;
        seg = 0;
      end else begin
        seg = i + 1;
      end
    endfunction

    task report(string what, frame_t got, frame_t want);
      $display("mismatch %s: got pix %0d se %0b qe %0b er %0b, %s %0d se %0b qe %0b er %0b",
               what, got.pixel, got.segment_end, got.sequence_end, got.error,
               "want pix", want.pixel, want.segment_end, want.sequence_end, want.error);
      mismatches++;
    endtask

    task check(frame_t got);
      frame_t want;
      if (frames_due.size() == 0) begin
        report("unexpected item", got, '0);
        return;
      end
      want = frames_due.pop_front();
      if (got.pixel !== want.pixel) report("pixel", got, want);
      if (got.segment_end !== want.segment_end) report("segment_end", got, want);
      if (got.sequence_end !== want.sequence_end) report("sequence_end", got, want);
      if (got.error !== want.error) report("error", got, want);
    endtask

    function int pending();
      return frames_due.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   send_burst;
  bit   recv_burst;
  int   sent;
  longint cycles;
  upsample_scoreboard sb;

  csu_in_if  in_if();
  csu_out_if out_if();
  csu_cfg_if cfg_if();

  cubic_spline_temporal_upsampler_core dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout");
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int stall;
    frame_t got;
    out_if.ready <= 1'b0;
    stall = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready) begin
        got.pixel = out_if.pixel;
        got.segment_end = out_if.segment_end;
        got.sequence_end = out_if.sequence_end;
        got.error = out_if.error;
        sb.check(got);
        if ($urandom_range(0, 63) == 0) recv_burst = !recv_burst;
        stall = recv_burst ? 0 : $urandom_range(0, 15);
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        stall--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(logic cmd, logic [csu_pkg::PIX_W-1:0] smp, logic last);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.cmd <= cmd;
    in_if.sample <= smp;
    in_if.last_sample <= last;
    do @(posedge clk); while (!in_if.ready);
    sb.note_input(cmd, smp, last);
    sent++;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_q(logic [csu_pkg::Q_W-1:0] v);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.q_factor <= v;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    sb.set_q(v);
  endtask

  task automatic load_run(int n, bit extremes);
    logic [csu_pkg::PIX_W-1:0] s;
    for (int k = 0; k < n; k++) begin
      if (extremes || $urandom_range(0, 3) == 0) begin
        s = $urandom_range(0, 1) ? csu_pkg::PIX_MAX : '0;
      end else begin
        s = csu_pkg::PIX_W'($urandom_range(0, 255));
      end
      send_item(csu_pkg::CMD_LOAD, s, k == n - 1);
    end
  endtask

  task automatic random_traffic(int target);
    int r, n, e;
    int stop_at;
    stop_at = sent + target;
    while (sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        send_item(csu_pkg::CMD_EMIT, csu_pkg::PIX_W'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      end else begin
        n = (r < 10) ? 1 : (r < 14) ? $urandom_range(7, 16) : $urandom_range(2, 5);
        load_run(n, r < 20);
        e = (n < 2) ? 1 : n - 1;
        r = $urandom_range(0, 9);
        if (r == 0) e = $urandom_range(0, e);
        else if (r == 1) e++;
        repeat (e) begin
          send_item(csu_pkg::CMD_EMIT, csu_pkg::PIX_W'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  initial begin
    logic [csu_pkg::Q_W-1:0] q_list [7];
    q_list = '{6'd0, 6'd1, 6'd3, 6'd63, 6'd32, 6'd2, 6'd17};
    sb = new();
    sent = 0;
    send_burst = 0;
    recv_burst = 0;
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.cmd <= csu_pkg::CMD_LOAD;
    in_if.sample <= '0;
    in_if.last_sample <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.q_factor <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // emit with nothing solved, then a lone sample
    send_item(csu_pkg::CMD_EMIT, 8'hff, 1'b1);
    send_item(csu_pkg::CMD_LOAD, 8'hff, 1'b1);
    send_item(csu_pkg::CMD_EMIT, 8'h00, 1'b0);
    send_item(csu_pkg::CMD_EMIT, 8'h00, 1'b0);
    // two extremes, full sequence then one emit too many
    send_item(csu_pkg::CMD_LOAD, 8'h00, 1'b0);
    send_item(csu_pkg::CMD_LOAD, 8'hff, 1'b1);
    send_item(csu_pkg::CMD_EMIT, 8'h00, 1'b0);
    send_item(csu_pkg::CMD_EMIT, 8'h00, 1'b0);
    // new sequence cuts the previous one short
    load_run(4, 1);
    send_item(csu_pkg::CMD_EMIT, 8'h55, 1'b0);
    load_run(3, 0);
    send_item(csu_pkg::CMD_EMIT, 8'haa, 1'b0);
    send_item(csu_pkg::CMD_EMIT, 8'haa, 1'b0);

    // overfull store: the last mark still solves
    write_q(6'd1);
    load_run(66, 0);
    repeat (63) send_item(csu_pkg::CMD_EMIT, 8'h00, 1'b0);

    foreach (q_list[p]) begin
      write_q(q_list[p]);
      random_traffic(q_list[p] >= 6'd17 && q_list[p] <= 6'd32 ? 25 : 22);
      if (p == 2) begin
        drain();
        random_traffic(20);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/csu_pkg.sv
sv/csu_in_if.sv
sv/csu_out_if.sv
sv/csu_cfg_if.sv
sv/csu_divider.sv
sv/csu_datapath.sv
sv/csu_ctrl.sv
sv/cubic_spline_temporal_upsampler_core.sv
tb/tb_cubic_spline_temporal_upsampler_core.sv
